// ----- design/ttt_pkg.sv -----
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types and constants of the timed task table: request and result
// layouts, operation and result codes, sequencer states.
// ----------------------------------------------------------------------------
package ttt_pkg;

	localparam int TABLE_SLOTS_DEF = 16;
	localparam int ID_BITS_DEF     = 16;
	localparam int MAX_FIRED       = 16;
	localparam int FIRED_W         = 5;
	localparam int TIME_W          = 32;
	localparam int HANDLE_W        = 16;
	localparam int ID_OUT_W        = 16;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_ADD     = 3'd0,
		KIND_REMOVE  = 3'd1,
		KIND_FIRED   = 3'd2,
		KIND_SUMMARY = 3'd3,
		KIND_CLEAR   = 3'd4
	} kind_t;

	typedef struct packed {
		op_t                 operation;
		logic [TIME_W-1:0]   now_ms;
		logic [TIME_W-1:0]   lead_ms;
		logic [TIME_W-1:0]   repeat_ms;
		logic [HANDLE_W-1:0] command_handle;
		logic [ID_OUT_W-1:0] task_id;
	} request_t;

	typedef struct packed {
		kind_t               result_kind;
		logic                success;
		logic [ID_OUT_W-1:0] id_out;
		logic [HANDLE_W-1:0] handle_out;
		logic                is_repeating;
		logic [FIRED_W-1:0]  fired_count;
		logic                last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_SCAN,
		ST_RM_READ,
		ST_RM_CHECK,
		ST_TK_READ,
		ST_TK_CHECK,
		ST_TK_UPDATE,
		ST_TK_SUMMARY
	} state_t;

endpackage

// ----- design/ttt_ram.sv -----
// ----------------------------------------------------------------------------
// ttt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ttt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/timed_task_table.sv -----
// ----------------------------------------------------------------------------
// timed_task_table
// Table of one-shot and periodic timed tasks with add, remove, tick and
// clear requests, scanned slot by slot through one entry RAM and one adder.
// ----------------------------------------------------------------------------
//  channel   signals                  handshake
//  request   start, busy, request     taken when start is high and busy is low
//  result    result_strobe, result    one cycle per result, cannot be held off
//
// Clear and a failing add answer in the cycle after the request.
// A successful add steps slot by slot up to the first free slot.
// Remove reads, then checks, slot after slot up to the match; a tick reads
// and checks each slot, rewrites each repeating task that fires and ends
// with the summary; the RAM's registered read splits read and check.
// Reset leaves the table empty with the id counter at one; no clearing pass.
// ----------------------------------------------------------------------------
module timed_task_table
	import ttt_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int ID_BITS     = ID_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     result_strobe,
	output result_t  result
);

	localparam int IDX_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
	localparam int ENTRY_W = ID_BITS + 2 * TIME_W + HANDLE_W;
	localparam int CMP_W   = (ID_BITS > ID_OUT_W) ? ID_BITS : ID_OUT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

	state_t                 state_q, state_d;
	logic [IDX_W-1:0]       idx_q, idx_d;
	request_t               req_q;
	logic                   load_req;
	logic [TABLE_SLOTS-1:0] valid_q, valid_d;
	logic [TABLE_SLOTS-1:0] pending_q, pending_d;
	logic [CNT_W-1:0]       used_q, used_d;
	logic [ID_BITS-1:0]     id_ctr_q, id_ctr_d, id_use;
	logic [FIRED_W-1:0]     fired_q, fired_d, fired_inc;
	result_t                result_q, res_d;
	logic                   strobe_q, emit;

	logic                   ram_we;
	logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;
	logic [ID_BITS-1:0]     ent_ident;
	logic [TIME_W-1:0]      ent_due, ent_period;
	logic [HANDLE_W-1:0]    ent_handle;

	logic [TIME_W-1:0]      add_b, add_sum;
	logic                   add_sub;
	logic                   fire, scan_end;

	ttt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign ent_ident  = ram_rdata[ENTRY_W-1 -: ID_BITS];
	assign ent_due    = ram_rdata[2*TIME_W+HANDLE_W-1 -: TIME_W];
	assign ent_period = ram_rdata[TIME_W+HANDLE_W-1 -: TIME_W];
	assign ent_handle = ram_rdata[HANDLE_W-1:0];

	assign add_sum = req_q.now_ms + (add_b ^ {TIME_W{add_sub}})
		+ {{(TIME_W-1){1'b0}}, add_sub};

	assign id_use    = (id_ctr_q == '0) ? ID_BITS'(1) : id_ctr_q;
	assign fired_inc = fired_q + FIRED_W'(1);
	assign fire      = valid_q[idx_q] && pending_q[idx_q] && !add_sum[TIME_W-1];

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		load_req  = 1'b0;
		valid_d   = valid_q;
		pending_d = pending_q;
		used_d    = used_q;
		id_ctr_d  = id_ctr_q;
		fired_d   = fired_q;
		emit      = 1'b0;
		res_d     = '0;
		ram_we    = 1'b0;
		ram_wdata = ram_rdata;
		add_b     = req_q.lead_ms;
		add_sub   = 1'b0;
		scan_end  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					load_req = 1'b1;
					idx_d    = '0;
					fired_d  = '0;
					unique case (request.operation)
						OP_ADD: begin
							if (request.command_handle == '0
								|| used_q == CNT_W'(TABLE_SLOTS)) begin
								emit              = 1'b1;
								res_d.result_kind = KIND_ADD;
								res_d.last        = 1'b1;
							end else begin
								state_d = ST_ADD_SCAN;
							end
						end
						OP_REMOVE: state_d = ST_RM_READ;
						OP_TICK:   state_d = ST_TK_READ;
						OP_CLEAR: begin
							valid_d           = '0;
							pending_d         = '0;
							used_d            = '0;
							id_ctr_d          = ID_BITS'(1);
							emit              = 1'b1;
							res_d.result_kind = KIND_CLEAR;
							res_d.success     = 1'b1;
							res_d.last        = 1'b1;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_SCAN: begin
				if (!valid_q[idx_q]) begin
					ram_we             = 1'b1;
					ram_wdata          = {id_use, add_sum, req_q.repeat_ms,
						req_q.command_handle};
					valid_d[idx_q]     = 1'b1;
					pending_d[idx_q]   = 1'b1;
					used_d             = used_q + CNT_W'(1);
					id_ctr_d           = id_use + ID_BITS'(1);
					emit               = 1'b1;
					res_d.result_kind  = KIND_ADD;
					res_d.success      = 1'b1;
					res_d.id_out       = ID_OUT_W'(id_use);
					res_d.last         = 1'b1;
					state_d            = ST_IDLE;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			ST_RM_READ: state_d = ST_RM_CHECK;
			ST_RM_CHECK: begin
				if (valid_q[idx_q] && req_q.task_id != '0
					&& CMP_W'(ent_ident) == CMP_W'(req_q.task_id)) begin
					valid_d[idx_q]    = 1'b0;
					pending_d[idx_q]  = 1'b0;
					used_d            = used_q - CNT_W'(1);
					emit              = 1'b1;
					res_d.result_kind = KIND_REMOVE;
					res_d.success     = 1'b1;
					res_d.last        = 1'b1;
					state_d           = ST_IDLE;
				end else if (idx_q == LAST_IDX) begin
					emit              = 1'b1;
					res_d.result_kind = KIND_REMOVE;
					res_d.last        = 1'b1;
					state_d           = ST_IDLE;
				end else begin
					idx_d   = idx_q + IDX_W'(1);
					state_d = ST_RM_READ;
				end
			end
			ST_TK_READ: state_d = ST_TK_CHECK;
			ST_TK_CHECK: begin
				add_b   = ent_due;
				add_sub = 1'b1;
				if (fire && ent_period != '0) begin
					state_d = ST_TK_UPDATE;
				end else begin
					if (fire) begin
						pending_d[idx_q]  = 1'b0;
						emit              = 1'b1;
						res_d.result_kind = KIND_FIRED;
						res_d.id_out      = ID_OUT_W'(ent_ident);
						res_d.handle_out  = ent_handle;
						fired_d           = fired_inc;
					end
					scan_end = (idx_q == LAST_IDX) || (fired_d == FIRED_W'(MAX_FIRED));
					if (scan_end) begin
						state_d = ST_TK_SUMMARY;
					end else begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = ST_TK_READ;
					end
				end
			end
			ST_TK_UPDATE: begin
				add_b              = ent_period;
				ram_we             = 1'b1;
				ram_wdata          = {ent_ident, add_sum, ent_period, ent_handle};
				emit               = 1'b1;
				res_d.result_kind  = KIND_FIRED;
				res_d.id_out       = ID_OUT_W'(ent_ident);
				res_d.handle_out   = ent_handle;
				res_d.is_repeating = 1'b1;
				fired_d            = fired_inc;
				scan_end = (idx_q == LAST_IDX) || (fired_inc == FIRED_W'(MAX_FIRED));
				if (scan_end) begin
					state_d = ST_TK_SUMMARY;
				end else begin
					idx_d   = idx_q + IDX_W'(1);
					state_d = ST_TK_READ;
				end
			end
			ST_TK_SUMMARY: begin
				emit              = 1'b1;
				res_d.result_kind = KIND_SUMMARY;
				res_d.fired_count = fired_q;
				res_d.last        = 1'b1;
				state_d           = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			valid_q   <= '0;
			pending_q <= '0;
			used_q    <= '0;
			id_ctr_q  <= ID_BITS'(1);
			fired_q   <= '0;
			strobe_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			valid_q   <= valid_d;
			pending_q <= pending_d;
			used_q    <= used_d;
			id_ctr_q  <= id_ctr_d;
			fired_q   <= fired_d;
			strobe_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (load_req) begin
			req_q <= request;
		end
		if (emit) begin
			result_q <= res_d;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = strobe_q;
	assign result        = result_q;

endmodule

// ----- design/ttt_checker.sv -----
// ----------------------------------------------------------------------------
// ttt_checker
// Port-level checks of the timed task table, bound to the top level.
// ----------------------------------------------------------------------------
module ttt_checker
	import ttt_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input request_t request,
	input logic     result_strobe,
	input result_t  result
);

	// A clear request is answered in the next cycle by a single acknowledge.
	a_clear_ack: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.operation == OP_CLEAR
		|=> result_strobe && result.result_kind == KIND_CLEAR && result.last)
		else $error("clear request not acknowledged in the next cycle");

	// A fired task is always followed by more results of the same tick.
	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.result_kind == KIND_FIRED |-> !result.last)
		else $error("fired task result marked as last");

	// While more results of a request are due the block takes no new request.
	a_busy_until_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last |-> busy)
		else $error("block idle before the last result of a request");

	// Remove and tick requests start a scan and give no result at once.
	a_scan_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy
		&& (request.operation == OP_REMOVE || request.operation == OP_TICK)
		|=> busy && !result_strobe)
		else $error("scan request did not start a scan");

endmodule

bind timed_task_table ttt_checker u_ttt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.request      (request),
	.result_strobe(result_strobe),
	.result       (result)
);

// ----- verif/task_table_checker.sv -----
// ----------------------------------------------------------------------------
// task_table_checker
// Watches the request and result channels of the timed task table, keeps its
// own copy of the task slots, predicts the answers of every accepted request
// and compares each result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module task_table_checker
	import ttt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  request_t request,
	input  logic     result_strobe,
	input  result_t  result,
	output int       errors,
	output int       outstanding
);

	localparam int SLOTS = TABLE_SLOTS_DEF;

	logic [ID_OUT_W-1:0]    slot_id       [SLOTS];
	logic [TIME_W-1:0]      slot_due_ms   [SLOTS];
	logic [TIME_W-1:0]      slot_every_ms [SLOTS];
	logic [HANDLE_W-1:0]    slot_cmd      [SLOTS];
	logic                   slot_armed    [SLOTS];
	int                     occupied;
	logic [ID_BITS_DEF-1:0] next_id;
	result_t                expected_answers[$];

	function automatic result_t answer(kind_t kind, logic ok, logic [ID_OUT_W-1:0] id,
			logic [HANDLE_W-1:0] handle, logic rep, logic [FIRED_W-1:0] cnt, logic fin);
		result_t r;
		r.result_kind  = kind;
		r.success      = ok;
		r.id_out       = id;
		r.handle_out   = handle;
		r.is_repeating = rep;
		r.fired_count  = cnt;
		r.last         = fin;
		return r;
	endfunction

	task automatic clear_table();
		for (int i = 0; i < SLOTS; i++) begin
			slot_id[i]       = '0;
			slot_due_ms[i]   = '0;
			slot_every_ms[i] = '0;
			slot_cmd[i]      = '0;
			slot_armed[i]    = 1'b0;
		end
		occupied = 0;
		next_id  = 1;
	endtask

	task automatic predict_answers(input request_t rq);
		int                     slot;
		int                     fired;
		logic                   ok;
		logic                   rep;
		logic [ID_BITS_DEF-1:0] id;
		logic [TIME_W-1:0]      lag;
		slot  = -1;
		fired = 0;
		ok    = 1'b0;
		case (rq.operation)
			OP_ADD: begin
				if (rq.command_handle != 0 && occupied < SLOTS) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (slot_id[i] == 0) begin
							slot = i;
							break;
						end
					end
				end
				if (slot < 0) begin
					expected_answers.push_back(answer(KIND_ADD, 1'b0, '0, '0, 1'b0, '0, 1'b1));
				end else begin
					id = next_id;
					if (id == 0)
						id = 1;
					next_id              = id + 1'b1;
					slot_id[slot]        = id;
					slot_due_ms[slot]    = rq.now_ms + rq.lead_ms;
					slot_every_ms[slot]  = rq.repeat_ms;
					slot_cmd[slot]       = rq.command_handle;
					slot_armed[slot]     = 1'b1;
					occupied++;
					expected_answers.push_back(answer(KIND_ADD, 1'b1, id, '0, 1'b0, '0, 1'b1));
				end
			end
			OP_REMOVE: begin
				if (rq.task_id != 0) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (slot_id[i] == rq.task_id) begin
							slot_id[i]       = '0;
							slot_due_ms[i]   = '0;
							slot_every_ms[i] = '0;
							slot_cmd[i]      = '0;
							slot_armed[i]    = 1'b0;
							if (occupied > 0)
								occupied--;
							ok = 1'b1;
							break;
						end
					end
				end
				expected_answers.push_back(answer(KIND_REMOVE, ok, '0, '0, 1'b0, '0, 1'b1));
			end
			OP_TICK: begin
				if (occupied != 0) begin
					for (int i = 0; i < SLOTS && fired < MAX_FIRED; i++) begin
						if (slot_id[i] == 0 || !slot_armed[i])
							continue;
						lag = rq.now_ms - slot_due_ms[i];
						if (lag[TIME_W-1])
							continue;
						rep = (slot_every_ms[i] != 0);
						if (rep)
							slot_due_ms[i] = rq.now_ms + slot_every_ms[i];
						else
							slot_armed[i] = 1'b0;
						expected_answers.push_back(answer(KIND_FIRED, 1'b0, slot_id[i],
							slot_cmd[i], rep, '0, 1'b0));
						fired++;
					end
				end
				expected_answers.push_back(answer(KIND_SUMMARY, 1'b0, '0, '0, 1'b0,
					FIRED_W'(fired), 1'b1));
			end
			default: begin
				clear_table();
				expected_answers.push_back(answer(KIND_CLEAR, 1'b1, '0, '0, 1'b0, '0, 1'b1));
			end
		endcase
	endtask

	task automatic report(input string what, input result_t got, input result_t want);
		errors++;
		if (errors <= 40)
			$display("%0t: %s: got %p, expected %p", $time, what, got, want);
	endtask

	task automatic check_answer(input result_t got);
		result_t want;
		if (expected_answers.size() == 0) begin
			report("result with no request waiting", got, got);
		end else begin
			want = expected_answers.pop_front();
			if (got.result_kind !== want.result_kind)
				report("result_kind", got, want);
			if (got.success !== want.success)
				report("success", got, want);
			if (got.id_out !== want.id_out)
				report("id_out", got, want);
			if (got.handle_out !== want.handle_out)
				report("handle_out", got, want);
			if (got.is_repeating !== want.is_repeating)
				report("is_repeating", got, want);
			if (got.fired_count !== want.fired_count)
				report("fired_count", got, want);
			if (got.last !== want.last)
				report("last", got, want);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_table();
			expected_answers.delete();
		end else begin
			if (result_strobe === 1'b1)
				check_answer(result);
			if (start && busy === 1'b0)
				predict_answers(request);
		end
		outstanding = expected_answers.size();
	end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the timed task table with a directed set of requests, a short run
// of add and remove pairs around a task that stays put, and random phases
// with and without sender gaps. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench
	import ttt_pkg::*;
();

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	request_t request;
	logic     result_strobe;
	result_t  result;
	int       errors;
	int       outstanding;

	logic [TIME_W-1:0] clock_ms;
	int unsigned       id_hint;
	int                idle_pct;

	timed_task_table u_top (
		.clk,
		.arst_n,
		.start,
		.busy,
		.request,
		.result_strobe,
		.result
	);

	task_table_checker u_checker (
		.clk,
		.arst_n,
		.start,
		.busy,
		.request,
		.result_strobe,
		.result,
		.errors,
		.outstanding
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	function automatic request_t make_request(op_t op, logic [TIME_W-1:0] now,
			logic [TIME_W-1:0] delay, logic [TIME_W-1:0] interval,
			logic [HANDLE_W-1:0] handle, logic [ID_OUT_W-1:0] id);
		request_t rq;
		rq.operation      = op;
		rq.now_ms         = now;
		rq.lead_ms        = delay;
		rq.repeat_ms      = interval;
		rq.command_handle = handle;
		rq.task_id        = id;
		return rq;
	endfunction

	task automatic pause(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic send(input request_t rq);
		@(negedge clk);
		start   <= 1'b1;
		request <= rq;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		if ($urandom_range(99) < idle_pct)
			pause($urandom_range(1, 12));
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic random_request();
		request_t rq;
		int       pick;
		pick              = $urandom_range(99);
		rq.operation      = op_t'($urandom_range(3));
		rq.now_ms         = $urandom();
		rq.lead_ms        = $urandom();
		rq.repeat_ms      = $urandom();
		rq.command_handle = HANDLE_W'($urandom());
		rq.task_id        = ID_OUT_W'($urandom());
		if (pick < 5) begin
			if (rq.operation == OP_CLEAR)
				id_hint = 0;
		end else if (pick < 40) begin
			rq.operation = OP_ADD;
			rq.now_ms    = clock_ms;
			if ($urandom_range(9) < 8)
				rq.lead_ms = $urandom_range(0, 60);
			case ($urandom_range(19))
				0, 1, 2:                 ;
				3, 4, 5, 6, 7, 8, 9, 10: rq.repeat_ms = 0;
				default:                 rq.repeat_ms = $urandom_range(1, 40);
			endcase
			if ($urandom_range(19) == 0)
				rq.command_handle = '0;
			else if (rq.command_handle == 0)
				rq.command_handle = HANDLE_W'(1);
			if (rq.command_handle != 0 && id_hint < 65535)
				id_hint++;
		end else if (pick < 62) begin
			rq.operation = OP_REMOVE;
			if ($urandom_range(9) < 8)
				rq.task_id = ID_OUT_W'($urandom_range(1, id_hint + 1));
		end else if (pick < 97) begin
			rq.operation = OP_TICK;
			if ($urandom_range(19) == 0)
				clock_ms = clock_ms + $urandom();
			else
				clock_ms = clock_ms + $urandom_range(0, 40);
			rq.now_ms = clock_ms;
		end else begin
			rq.operation = OP_CLEAR;
			id_hint      = 0;
		end
		send(rq);
	endtask

	initial begin
		logic [TIME_W-1:0] delay;
		logic [TIME_W-1:0] interval;

		clk      = 1'b0;
		arst_n   = 1'b0;
		start    = 1'b0;
		request  = '0;
		idle_pct = 0;
		clock_ms = 1000;
		id_hint  = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send(make_request(OP_TICK, clock_ms, 0, 0, 0, 0));
		send(make_request(OP_ADD, clock_ms, 5, 0, 16'h0000, 0));
		send(make_request(OP_REMOVE, clock_ms, 0, 0, 0, 16'h0000));
		for (int k = 0; k < TABLE_SLOTS_DEF; k++) begin
			case (k)
				0:       begin delay = '0;           interval = '0;           end
				1:       begin delay = '1;           interval = '1;           end
				2:       begin delay = 32'h7FFF_FFFF; interval = 7;           end
				3:       begin delay = 32'h8000_0000; interval = '0;           end
				default: begin delay = k;            interval = (k % 2) ? k : 0; end
			endcase
			send(make_request(OP_ADD, clock_ms, delay, interval,
				(k == 0) ? 16'hFFFF : HANDLE_W'(k * 4097 + 1), 0));
		end
		send(make_request(OP_ADD, clock_ms, 0, 0, 16'h1234, 0));
		send(make_request(OP_TICK, clock_ms + 20, 0, 0, 0, 0));
		send(make_request(OP_REMOVE, clock_ms, 0, 0, 0, 16'd3));
		send(make_request(OP_REMOVE, clock_ms, 0, 0, 0, 16'd3));
		send(make_request(OP_CLEAR, clock_ms, 0, 0, 0, 0));
		drain();

		// Add and remove pairs while the task with id one stays put.
		send(make_request(OP_ADD, clock_ms, 100, 0, 16'h00AA, 0));
		for (int k = 2; k < 10; k++) begin
			send(make_request(OP_ADD, clock_ms, 100, 0, 16'h0055, 0));
			send(make_request(OP_REMOVE, clock_ms, 0, 0, 0, ID_OUT_W'(k)));
		end
		send(make_request(OP_ADD, clock_ms, 0, 3, 16'h0077, 0));
		send(make_request(OP_TICK, clock_ms + 200, 0, 0, 0, 0));
		send(make_request(OP_REMOVE, clock_ms, 0, 0, 0, 16'd1));
		send(make_request(OP_REMOVE, clock_ms, 0, 0, 0, 16'd1));
		send(make_request(OP_REMOVE, clock_ms, 0, 0, 0, 16'd1));
		drain();

		send(make_request(OP_CLEAR, clock_ms, 0, 0, 0, 0));
		for (int p = 0; p < 4; p++) begin
			case (p)
				1:       idle_pct = 48;
				2:       idle_pct = 37;
				default: idle_pct = 0;
			endcase
			clock_ms = (p == 3) ? 32'hFFFF_FF00 : $urandom();
			for (int n = 0; n < 33; n++)
				random_request();
			drain();
		end

		if (errors == 0 && outstanding == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
design/ttt_pkg.sv
design/ttt_ram.sv
design/timed_task_table.sv
design/ttt_checker.sv
verif/task_table_checker.sv
verif/testbench.sv
